### rtl/ccms_pkg.sv
package ccms_pkg;

  localparam int FREQ_W   = 40;
  localparam int SEC_W    = 12;
  localparam int MULT_W   = 32;
  localparam int SHIFT_W  = 6;

  // multiplier width allowed before the overflow bound trims it
  localparam int MULT_WIDTH = 32;

  localparam int PROD_W   = FREQ_W + SEC_W;
  localparam int SPAN_W   = PROD_W - MULT_WIDTH;
  localparam int DIVD_W   = 64;
  localparam int NS_W     = 62;
  localparam int DCNT_W   = 6;

  localparam logic [SHIFT_W-1:0] MAX_SHIFT = SHIFT_W'(32);
  localparam logic [SEC_W-1:0]   RESET_MAX_SECONDS = SEC_W'(600);
  localparam logic [NS_W-1:0]    NS_PER_SEC = NS_W'(1000000000);
  localparam logic [NS_W-1:0]    NS_TOP = NS_PER_SEC << MAX_SHIFT;

  typedef struct packed {
    logic [MULT_W-1:0]  mult;
    logic [SHIFT_W-1:0] shift;
    logic               valid_res;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_WIDTH,
    S_DSTART,
    S_DWAIT,
    S_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_DONE
  } div_state_t;

endpackage

### rtl/ccms_div.sv
module ccms_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ccms_pkg::DIVD_W-1:0]   dividend,
  input  logic [ccms_pkg::FREQ_W-1:0]   divisor,
  output logic                          done,
  output logic [ccms_pkg::DIVD_W-1:0]   quotient
);
  import ccms_pkg::*;

  div_state_t              state;
  div_state_t              state_next;
  logic [DCNT_W-1:0]       cnt;
  logic [FREQ_W-1:0]       dvsr;
  logic [FREQ_W-1:0]       rem;
  logic [DIVD_W-1:0]       dq;
  logic [FREQ_W:0]         trial;
  logic                    qbit;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  assign trial = {rem, dq[DIVD_W-1]};
  assign qbit  = (trial >= {1'b0, dvsr});

  always_comb begin
    state_next = state;
    case (state)
      D_IDLE:  if (start) state_next = D_RUN;
      D_RUN:   if (cnt == '1) state_next = D_DONE;
      D_DONE:  state_next = D_IDLE;
      default: state_next = D_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      D_DONE:  done = 1'b1;
      default: done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == D_IDLE && start) begin
      dvsr <= divisor;
      rem  <= '0;
      dq   <= dividend;
      cnt  <= '0;
    end else if (state == D_RUN) begin
      rem  <= qbit ? FREQ_W'(trial - {1'b0, dvsr}) : trial[FREQ_W-1:0];
      dq   <= {dq[DIVD_W-2:0], qbit};
      cnt  <= cnt + DCNT_W'(1);
    end
  end

  assign quotient = dq;

endmodule

### rtl/ccms_seq.sv
module ccms_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ccms_pkg::FREQ_W-1:0]   freq_in,
  input  logic [ccms_pkg::SEC_W-1:0]    max_seconds,
  output logic                          ready,
  output logic                          res_valid,
  input  logic                          res_ready,
  output ccms_pkg::res_t                res
);
  import ccms_pkg::*;

  seq_state_t           state;
  seq_state_t           state_next;
  logic [FREQ_W-1:0]    freq;
  logic [PROD_W-1:0]    prod;
  logic [PROD_W-1:0]    mcand;
  logic [SEC_W-1:0]     msec;
  logic [SPAN_W-1:0]    span;
  logic [SHIFT_W-1:0]   acc;
  logic [SHIFT_W-1:0]   s;
  logic [NS_W-1:0]      nsv;
  logic                 div_start;
  logic                 div_done;
  logic [DIVD_W-1:0]    q;
  logic [DIVD_W-1:0]    dividend;
  logic                 fit;

  assign dividend = DIVD_W'(nsv) + DIVD_W'(freq >> 1);
  assign fit      = ((q >> acc) == '0);

  ccms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (freq),
    .done     (div_done),
    .quotient (q)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = (freq_in == '0) ? S_DONE : S_MUL;
      end
      S_MUL: begin
        if (msec == '0) state_next = S_WIDTH;
      end
      S_WIDTH: begin
        if (span == '0) state_next = S_DSTART;
      end
      S_DSTART: state_next = S_DWAIT;
      S_DWAIT: begin
        if (div_done) state_next = (fit || s == SHIFT_W'(1)) ? S_DONE : S_DSTART;
      end
      S_DONE: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ready     = 1'b0;
    res_valid = 1'b0;
    div_start = 1'b0;
    case (state)
      S_IDLE:   ready     = 1'b1;
      S_DSTART: div_start = 1'b1;
      S_DONE:   res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          freq  <= freq_in;
          mcand <= PROD_W'(freq_in);
          msec  <= max_seconds;
          prod  <= '0;
          s     <= MAX_SHIFT;
          nsv   <= NS_TOP;
          res   <= '0;
        end
      end
      S_MUL: begin
        // shift-add multiply of max_seconds by the frequency
        prod  <= prod + (msec[0] ? mcand : '0);
        mcand <= mcand << 1;
        msec  <= msec >> 1;
        if (msec == '0) begin
          span <= prod[PROD_W-1:MULT_WIDTH];
          acc  <= SHIFT_W'(MULT_WIDTH);
        end
      end
      S_WIDTH: begin
        // drop one bit of allowed width per significant bit of the span
        if (span != '0) begin
          span <= span >> 1;
          if (acc != '0) acc <= acc - SHIFT_W'(1);
        end
      end
      S_DWAIT: begin
        if (div_done) begin
          if (fit) begin
            res.mult      <= q[MULT_W-1:0];
            res.shift     <= s;
            res.valid_res <= 1'b1;
          end else if (s == SHIFT_W'(1)) begin
            res.mult      <= q[MULT_W-1:0];
            res.shift     <= '0;
            res.valid_res <= 1'b1;
          end else begin
            s   <= s - SHIFT_W'(1);
            nsv <= nsv >> 1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/clock_mult_shift_calc.sv
// Clock multiplier/shift calculator. Each request carries a counter frequency
// in Hz and returns (mult, shift) so that ns = (ticks * mult) >> shift, with
// mult narrow enough that ticks * mult stays within 64 bits for max_seconds of
// counting. One request is worked at a time; in_ready stays low until the
// sequencer is idle again. Cost is set by a 64-step restoring divider that is
// reused for every trial shift, 32 down to 1 trials, after a shift-add
// multiply of max_seconds by the frequency and a width search. A zero
// frequency is answered with valid_res low. The finished result sits in an
// output register, so a new request may start while it waits.
module clock_mult_shift_calc (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ccms_pkg::FREQ_W-1:0]   frequency_hz,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ccms_pkg::MULT_W-1:0]   mult,
  output logic [ccms_pkg::SHIFT_W-1:0]  shift,
  output logic                          valid_res,
  input  logic                          cfg_wr_en,
  input  logic [ccms_pkg::SEC_W-1:0]    cfg_wr_data
);
  import ccms_pkg::*;

  logic [SEC_W-1:0] max_seconds;
  logic             seq_ready;
  logic             res_valid;
  logic             res_ready;
  res_t             res;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_seconds <= RESET_MAX_SECONDS;
    end else if (cfg_wr_en) begin
      max_seconds <= cfg_wr_data;
    end
  end

  assign in_ready  = seq_ready;
  assign res_ready = !out_valid || out_ready;

  ccms_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (in_valid && seq_ready),
    .freq_in     (frequency_hz),
    .max_seconds (max_seconds),
    .ready       (seq_ready),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      mult      <= res.mult;
      shift     <= res.shift;
      valid_res <= res.valid_res;
    end
  end

endmodule

### rtl/ccms_chk.sv
module ccms_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [ccms_pkg::FREQ_W-1:0]   frequency_hz,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ccms_pkg::MULT_W-1:0]   mult,
  input logic [ccms_pkg::SHIFT_W-1:0]  shift,
  input logic                          valid_res,
  input logic                          cfg_wr_en,
  input logic [ccms_pkg::SEC_W-1:0]    cfg_wr_data
);

  // a result left waiting holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mult) && $stable(shift)
      && $stable(valid_res))
    else $error("result changed while stalled");

  // one request in flight: no accept right after an accept
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_zero_res: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> mult == '0 && shift == '0)
    else $error("invalid result carries nonzero fields");

  a_shift_rng: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> shift <= 6'd32)
    else $error("shift out of range");

endmodule

bind clock_mult_shift_calc ccms_chk u_ccms_chk (.*);
